// ----- rtl/spectral_current_correction_defines.svh -----
// assertion macros for the rtl of the spectral current correction (used by scc_finish)
`ifndef SPECTRAL_CURRENT_CORRECTION_DEFINES_SVH
`define SPECTRAL_CURRENT_CORRECTION_DEFINES_SVH

// same-cycle implication
`define SCC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scc check failed");

// next-cycle implication
`define SCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scc check failed");

`endif

// ----- rtl/scc_pkg.sv -----
// shared constants for the spectral current correction
package scc_pkg;
   localparam int FIELD_W = 64;
   localparam int WAVE_W = 32;
   localparam int CFG_W = 32;
   localparam int LANES = 6;
   localparam logic [CFG_W-1:0] INV_STEP_RESET = 32'd65536;
endpackage

// ----- rtl/spectral_current_correction.sv -----
// top level of the spectral current correction
// Corrects one spectral grid point per word so that the current obeys charge
// continuity: t = k.J - i*(rho_new - rho_old)/dt, result J - t*k/|k|^2, with the
// quotient truncated toward zero and each part saturated to signed PART_WIDTH
// (clipped flags any saturation). A zero wavevector passes the current through.
// Throughput is one word per cycle while rsp_ready lets the pipe advance. The
// path runs through five front stages (operands, products, sums, split partial
// products, numerator), one restoring-divider stage per quotient bit (PART_WIDTH
// + 33 of them) and the output register. The whole pipe advances together and
// holds while a finished word waits on rsp_ready, so nothing is lost or repeated.
// inv_time_step (unsigned Q16.16, 1.0 after reset) is written via csr_wr_en and
// should only change while the pipe is empty.
module spectral_current_correction #(
   parameter int PART_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // input words
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [scc_pkg::FIELD_W-1:0]     req_cur_x,
   input  logic [scc_pkg::FIELD_W-1:0]     req_cur_y,
   input  logic [scc_pkg::FIELD_W-1:0]     req_cur_z,
   input  logic [scc_pkg::FIELD_W-1:0]     req_charge_old,
   input  logic [scc_pkg::FIELD_W-1:0]     req_charge_new,
   input  logic signed [scc_pkg::WAVE_W-1:0] req_wave_x,
   input  logic signed [scc_pkg::WAVE_W-1:0] req_wave_y,
   input  logic signed [scc_pkg::WAVE_W-1:0] req_wave_z,
   // result words
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [scc_pkg::FIELD_W-1:0]     rsp_fixed_x,
   output logic [scc_pkg::FIELD_W-1:0]     rsp_fixed_y,
   output logic [scc_pkg::FIELD_W-1:0]     rsp_fixed_z,
   output logic                            rsp_clipped,
   // register write
   input  logic                            csr_wr_en,
   input  logic [scc_pkg::CFG_W-1:0]       csr_wr_data
);
   localparam int TM = PART_WIDTH + 33;   // quotient magnitude bits
   localparam int NB = TM + 32;           // numerator bits
   localparam int TGW = 6 * PART_WIDTH + 7;
   localparam int NL = scc_pkg::LANES;

   logic [scc_pkg::CFG_W-1:0] inv_step_ff;
   logic                      en;
   logic                      fr_valid, dv_valid;
   logic [NL-1:0][NB-1:0]     fr_num;
   logic [63:0]               fr_den;
   logic [TGW-1:0]            fr_tag, dv_tag;
   logic [NL-1:0][TM-1:0]     dv_quo;

   // 1/dt register
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_step_ff <= scc_pkg::INV_STEP_RESET;
      end else if (csr_wr_en) begin
         inv_step_ff <= csr_wr_data;
      end
   end

   // whole pipe moves unless a finished word is held at the output
   assign en = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // products, t, |k|^2 and the six numerators |t|*|k_c|
   scc_front #(
      .PW (PART_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_valid),
      .cur_x         (req_cur_x),
      .cur_y         (req_cur_y),
      .cur_z         (req_cur_z),
      .charge_old    (req_charge_old),
      .charge_new    (req_charge_new),
      .wave_x        (req_wave_x),
      .wave_y        (req_wave_y),
      .wave_z        (req_wave_z),
      .inv_time_step (inv_step_ff),
      .out_valid     (fr_valid),
      .out_num       (fr_num),
      .out_den       (fr_den),
      .out_tag       (fr_tag)
   );

   // six quotients by |k|^2, one bit a stage
   scc_divider #(
      .NB    (NB),
      .TM    (TM),
      .DW    (64),
      .LANES (NL),
      .TGW   (TGW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_num    (fr_num),
      .in_den    (fr_den),
      .in_tag    (fr_tag),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_tag   (dv_tag)
   );

   // signed subtract, saturation, output register
   scc_finish #(
      .PW (PART_WIDTH),
      .TM (TM)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid),
      .in_quo    (dv_quo),
      .in_tag    (dv_tag),
      .out_valid (rsp_valid),
      .fixed_x   (rsp_fixed_x),
      .fixed_y   (rsp_fixed_y),
      .fixed_z   (rsp_fixed_z),
      .clipped   (rsp_clipped)
   );
endmodule

// ----- rtl/scc_front.sv -----
// front pipeline: products, t, |k|^2 and the numerators of the six quotients
module scc_front #(
   parameter int PW = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [scc_pkg::FIELD_W-1:0] cur_x,
   input  logic [scc_pkg::FIELD_W-1:0] cur_y,
   input  logic [scc_pkg::FIELD_W-1:0] cur_z,
   input  logic [scc_pkg::FIELD_W-1:0] charge_old,
   input  logic [scc_pkg::FIELD_W-1:0] charge_new,
   input  logic signed [scc_pkg::WAVE_W-1:0] wave_x,
   input  logic signed [scc_pkg::WAVE_W-1:0] wave_y,
   input  logic signed [scc_pkg::WAVE_W-1:0] wave_z,
   input  logic [scc_pkg::CFG_W-1:0] inv_time_step,
   output logic                    out_valid,
   output logic [scc_pkg::LANES-1:0][2*PW+65-PW-1:0] out_num,
   output logic [63:0]             out_den,
   output logic [6*PW+6:0]         out_tag
);
   localparam int KW = scc_pkg::WAVE_W;
   localparam int TS = PW + 34;
   localparam int TM = PW + 33;
   localparam int H = (TM + 1) / 2;
   localparam int NB = TM + 32;
   localparam int NL = scc_pkg::LANES;

   logic [scc_pkg::FIELD_W-1:0] cur_a [3];
   logic signed [KW-1:0] wave_a [3];

   // stage 1
   logic signed [PW-1:0] jre1_ff [3], jim1_ff [3], jre1_in [3], jim1_in [3];
   logic signed [KW-1:0] k1_ff [3];
   logic [KW-1:0]        kmag1_ff [3], kmag1_in [3];
   logic signed [PW:0]   dre1_ff, dim1_ff, dre1_in, dim1_in;
   // stage 2
   logic signed [PW+KW-1:0] kjre2_ff [3], kjim2_ff [3], kjre2_in [3], kjim2_in [3];
   logic signed [TS-1:0] pre2_ff, pim2_ff, pre2_in, pim2_in;
   logic [63:0]          sq2_ff [3], sq2_in [3];
   logic signed [PW-1:0] jre2_ff [3], jim2_ff [3];
   logic [KW-1:0]        kmag2_ff [3];
   logic [2:0]           ks2_ff;
   logic                 zero2_ff, zero2_in;
   // stage 3
   logic signed [TS-1:0] tre3_ff, tim3_ff, tre3_in, tim3_in;
   logic [63:0]          den3_ff, den3_in;
   logic signed [PW-1:0] jre3_ff [3], jim3_ff [3];
   logic [KW-1:0]        kmag3_ff [3];
   logic [2:0]           ks3_ff;
   logic                 zero3_ff;
   // stage 4
   logic [TM-1:0]        tmag_in [2];
   logic [H+KW-1:0]      plo4_ff [NL], plo4_in [NL];
   logic [TM-H+KW-1:0]   phi4_ff [NL], phi4_in [NL];
   logic [63:0]          den4_ff;
   logic [6*PW+6:0]      tag4_ff, tag4_in;
   // stage 5
   logic [NB-1:0]        num5_ff [NL], num5_in [NL];
   logic [63:0]          den5_ff;
   logic [6*PW+6:0]      tag5_ff;
   logic [4:0]           vld_ff;

   assign cur_a[0] = cur_x;
   assign cur_a[1] = cur_y;
   assign cur_a[2] = cur_z;
   assign wave_a[0] = wave_x;
   assign wave_a[1] = wave_y;
   assign wave_a[2] = wave_z;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         jre1_in[c] = $signed(cur_a[c][2*PW-1:PW]);
         jim1_in[c] = $signed(cur_a[c][PW-1:0]);
         kmag1_in[c] = wave_a[c][KW-1] ? (~wave_a[c] + 1'b1) : wave_a[c];
         kjre2_in[c] = k1_ff[c] * jre1_ff[c];
         kjim2_in[c] = k1_ff[c] * jim1_ff[c];
         sq2_in[c] = kmag1_ff[c] * kmag1_ff[c];
      end
      dre1_in = (PW+1)'($signed(charge_new[2*PW-1:PW]))
              - (PW+1)'($signed(charge_old[2*PW-1:PW]));
      dim1_in = (PW+1)'($signed(charge_new[PW-1:0]))
              - (PW+1)'($signed(charge_old[PW-1:0]));
      pre2_in = dre1_ff * $signed({1'b0, inv_time_step});
      pim2_in = dim1_ff * $signed({1'b0, inv_time_step});
      zero2_in = (kmag1_ff[0] == '0) && (kmag1_ff[1] == '0) && (kmag1_ff[2] == '0);
      // t = k.J - i * d / dt
      tre3_in = TS'(kjre2_ff[0]) + TS'(kjre2_ff[1]) + TS'(kjre2_ff[2]) + pim2_ff;
      tim3_in = TS'(kjim2_ff[0]) + TS'(kjim2_ff[1]) + TS'(kjim2_ff[2]) - pre2_ff;
      den3_in = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
      tmag_in[0] = tre3_ff[TS-1] ? TM'(-tre3_ff) : TM'(tre3_ff);
      tmag_in[1] = tim3_ff[TS-1] ? TM'(-tim3_ff) : TM'(tim3_ff);
      tag4_in = '0;
      tag4_in[6*PW+6] = zero3_ff;
      for (int l = 0; l < NL; l++) begin
         plo4_in[l] = tmag_in[l%2][H-1:0] * kmag3_ff[l/2];
         phi4_in[l] = tmag_in[l%2][TM-1:H] * kmag3_ff[l/2];
         tag4_in[6*PW+l] = (l % 2 == 0 ? tre3_ff[TS-1] : tim3_ff[TS-1]) ^ ks3_ff[l/2];
         tag4_in[l*PW +: PW] = (l % 2 == 0) ? jre3_ff[l/2] : jim3_ff[l/2];
         num5_in[l] = NB'(plo4_ff[l]) + {phi4_ff[l], {H{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            jre1_ff[c] <= jre1_in[c];
            jim1_ff[c] <= jim1_in[c];
            k1_ff[c] <= wave_a[c];
            kmag1_ff[c] <= kmag1_in[c];
            kjre2_ff[c] <= kjre2_in[c];
            kjim2_ff[c] <= kjim2_in[c];
            sq2_ff[c] <= sq2_in[c];
            jre2_ff[c] <= jre1_ff[c];
            jim2_ff[c] <= jim1_ff[c];
            kmag2_ff[c] <= kmag1_ff[c];
            ks2_ff[c] <= k1_ff[c][KW-1];
            jre3_ff[c] <= jre2_ff[c];
            jim3_ff[c] <= jim2_ff[c];
            kmag3_ff[c] <= kmag2_ff[c];
         end
         dre1_ff <= dre1_in;
         dim1_ff <= dim1_in;
         pre2_ff <= pre2_in;
         pim2_ff <= pim2_in;
         zero2_ff <= zero2_in;
         tre3_ff <= tre3_in;
         tim3_ff <= tim3_in;
         den3_ff <= den3_in;
         ks3_ff <= ks2_ff;
         zero3_ff <= zero2_ff;
         for (int l = 0; l < NL; l++) begin
            plo4_ff[l] <= plo4_in[l];
            phi4_ff[l] <= phi4_in[l];
            num5_ff[l] <= num5_in[l];
         end
         den4_ff <= den3_ff;
         tag4_ff <= tag4_in;
         den5_ff <= den4_ff;
         tag5_ff <= tag4_ff;
      end
   end

   assign out_valid = vld_ff[4];
   assign out_den = den5_ff;
   assign out_tag = tag5_ff;
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         out_num[l] = num5_ff[l];
      end
   end
endmodule

// ----- rtl/scc_divider.sv -----
// pipelined restoring divider, one quotient bit per stage, shared divisor
module scc_divider #(
   parameter int NB = 97,
   parameter int TM = 65,
   parameter int DW = 64,
   parameter int LANES = 6,
   parameter int TGW = 199
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NB-1:0]    in_num,
   input  logic [DW-1:0]               in_den,
   input  logic [TGW-1:0]              in_tag,
   output logic                        out_valid,
   output logic [LANES-1:0][TM-1:0]    out_quo,
   output logic [TGW-1:0]              out_tag
);
   logic [DW-1:0]  rem_ff [TM][LANES], rem_in [TM][LANES];
   logic [TM-1:0]  bits_ff [TM][LANES], bits_in [TM][LANES];
   logic [DW-1:0]  den_ff [TM];
   logic [TGW-1:0] tag_ff [TM];
   logic [TM-1:0]  vld_ff;

   always_comb begin
      logic [DW-1:0] p_rem;
      logic [TM-1:0] p_bits;
      logic [DW-1:0] p_den;
      logic [DW:0]   trial;
      logic          ge;
      for (int s = 0; s < TM; s++) begin
         for (int l = 0; l < LANES; l++) begin
            // the quotient fits in TM bits, so the upper numerator bits seed the remainder
            if (s == 0) begin
               p_rem = DW'(in_num[l][NB-1:TM]);
               p_bits = in_num[l][TM-1:0];
               p_den = in_den;
            end else begin
               p_rem = rem_ff[s-1][l];
               p_bits = bits_ff[s-1][l];
               p_den = den_ff[s-1];
            end
            trial = {p_rem, p_bits[TM-1]};
            ge = trial >= {1'b0, p_den};
            rem_in[s][l] = ge ? DW'(trial - {1'b0, p_den}) : DW'(trial);
            bits_in[s][l] = {p_bits[TM-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TM-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < TM; s++) begin
            for (int l = 0; l < LANES; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               bits_ff[s][l] <= bits_in[s][l];
            end
            den_ff[s] <= (s == 0) ? in_den : den_ff[(s == 0) ? 0 : s-1];
            tag_ff[s] <= (s == 0) ? in_tag : tag_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign out_valid = vld_ff[TM-1];
   assign out_tag = tag_ff[TM-1];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = bits_ff[TM-1][l];
      end
   end
endmodule

// ----- rtl/scc_finish.sv -----
// sign, subtract, saturate and output register
`include "spectral_current_correction_defines.svh"
module scc_finish #(
   parameter int PW = 32,
   parameter int TM = 65
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [scc_pkg::LANES-1:0][TM-1:0] in_quo,
   input  logic [6*PW+6:0]                   in_tag,
   output logic                              out_valid,
   output logic [scc_pkg::FIELD_W-1:0]       fixed_x,
   output logic [scc_pkg::FIELD_W-1:0]       fixed_y,
   output logic [scc_pkg::FIELD_W-1:0]       fixed_z,
   output logic                              clipped
);
   localparam int RW = TM + 2;
   localparam int FW = scc_pkg::FIELD_W;
   localparam int NL = scc_pkg::LANES;
   localparam logic signed [RW-1:0] PMAX = {{(RW-PW+1){1'b0}}, {(PW-1){1'b1}}};
   localparam logic signed [RW-1:0] PMIN = {{(RW-PW+1){1'b1}}, {(PW-1){1'b0}}};

   logic [PW-1:0]        part_in [NL];
   logic                 clip_in, zero_in;
   logic [FW-1:0]        fixed_ff [3], fixed_in [3];
   logic                 valid_ff, clip_ff;
   logic                 limit_seen;

   always_comb begin
      logic signed [PW-1:0] j;
      logic signed [RW-1:0] jx, qx, diff;
      logic                 neg;
      zero_in = in_tag[6*PW+6];
      clip_in = 1'b0;
      for (int l = 0; l < NL; l++) begin
         j = in_tag[l*PW +: PW];
         neg = in_tag[6*PW+l];
         jx = RW'(j);
         qx = $signed(RW'(in_quo[l]));
         diff = neg ? (jx + qx) : (jx - qx);
         if (zero_in) begin
            part_in[l] = j;
         end else if (diff > PMAX) begin
            part_in[l] = PMAX[PW-1:0];
            clip_in = 1'b1;
         end else if (diff < PMIN) begin
            part_in[l] = PMIN[PW-1:0];
            clip_in = 1'b1;
         end else begin
            part_in[l] = diff[PW-1:0];
         end
      end
      for (int c = 0; c < 3; c++) begin
         fixed_in[c] = FW'({part_in[2*c], part_in[2*c+1]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            fixed_ff[c] <= fixed_in[c];
         end
         clip_ff <= clip_in;
      end
   end

   assign out_valid = valid_ff;
   assign fixed_x = fixed_ff[0];
   assign fixed_y = fixed_ff[1];
   assign fixed_z = fixed_ff[2];
   assign clipped = clip_ff;

   always_comb begin
      limit_seen = 1'b0;
      for (int c = 0; c < 3; c++) begin
         if (fixed_ff[c][2*PW-1:PW] == PMAX[PW-1:0] || fixed_ff[c][2*PW-1:PW] == PMIN[PW-1:0]
             || fixed_ff[c][PW-1:0] == PMAX[PW-1:0] || fixed_ff[c][PW-1:0] == PMIN[PW-1:0]) begin
            limit_seen = 1'b1;
         end
      end
   end

   `SCC_ASSERT_NEXT(a_zero_wave_no_clip, clock, reset, en && in_valid && zero_in, !clip_ff)
   `SCC_ASSERT_IMPL(a_clip_at_limit, clock, reset, valid_ff && clip_ff, limit_seen)
   `SCC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !valid_ff)
endmodule
